// ----- rtl/core/integer_execute_unit_macros.svh -----
// Assertion macros shared by the execute unit. All of them sample on the
// rising edge of aclk and are disabled while aresetn is low.
`ifndef INTEGER_EXECUTE_UNIT_MACROS_SVH
`define INTEGER_EXECUTE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IEXU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("execute unit assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IEXU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("execute unit assertion failed");

`endif

// ----- rtl/core/iexu_pkg.sv -----
package iexu_pkg;

    localparam logic [6:0] OPC_HALT   = 7'h00;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_LOADF  = 7'h07;
    localparam logic [6:0] OPC_RXBU   = 7'h0B;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_TXBU   = 7'h1B;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_STOREF = 7'h27;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_OPFP   = 7'h53;
    localparam logic [6:0] OPC_CUSTOM = 7'h5B;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BR2  = 3'd2;
    localparam logic [2:0] F3_BR3  = 3'd3;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_MUL10 = 3'd0;
    localparam logic [2:0] F3_DIV10 = 3'd1;
    localparam logic [2:0] F3_JALR  = 3'd0;

    localparam logic [1:0] OUTCOME_DONE    = 2'd0;
    localparam logic [1:0] OUTCOME_ILLEGAL = 2'd1;
    localparam logic [1:0] OUTCOME_HALT    = 2'd2;
    localparam logic [1:0] OUTCOME_OTHER   = 2'd3;

    // Reciprocal of 10 scaled by 2^35; exact for every 32-bit dividend.
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    typedef struct packed {
        logic [6:0]         opcode;
        logic [2:0]         funct3;
        logic [6:0]         funct7;
        logic [4:0]         rs2_field;
        logic signed [31:0] immediate;
        logic signed [31:0] src1_value;
        logic signed [31:0] src2_value;
        logic [31:0]        current_pc;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               write_dest;
        logic [31:0]        next_pc;
        logic [1:0]         outcome;
    } out_item_t;

    typedef struct packed {
        logic legal;
        logic taken;
    } branch_status_t;

endpackage

// ----- rtl/core/integer_execute_unit.sv -----
// Integer execute unit: ALU, branch compare, jumps and the mul10/div10 ops.
// The accepted item waits in the input register; its result and m_valid are loaded
// into the result register when that register is empty or being drained by m_ready.
// Throughput: one item per cycle while m_ready keeps draining the result register.
// Reset: synchronous active-low aresetn empties both stages; no other state.
`include "integer_execute_unit_macros.svh"

module integer_execute_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  iexu_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output iexu_pkg::out_item_t m_item
);

    logic                in_valid_reg;
    logic                in_valid_next;
    iexu_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    iexu_pkg::out_item_t out_item_reg;
    iexu_pkg::out_item_t out_item_next;
    logic                stage_advance;

    logic [31:0] imm;
    logic [31:0] src_a;
    logic [31:0] src_b;
    logic [31:0] pc;
    logic [31:0] pc_plus1;
    logic        is_reg_op;
    logic [31:0] alu_b;
    logic [31:0] alu_result;
    logic        alu_legal;
    logic [31:0] times10;
    logic [31:0] div10;
    iexu_pkg::branch_status_t br_status;

    logic [31:0] res;
    logic        wr;
    logic [31:0] npc;
    logic [1:0]  outc;
    logic        ok;

    // The input stage may fill while a finished result waits downstream.
    assign stage_advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready       = !in_valid_reg || stage_advance;
    assign m_valid       = out_valid_reg;
    assign m_item        = out_item_reg;

    assign imm       = in_item_reg.immediate;
    assign src_a     = in_item_reg.src1_value;
    assign src_b     = in_item_reg.src2_value;
    assign pc        = in_item_reg.current_pc;
    assign pc_plus1  = pc + 32'd1;
    assign is_reg_op = in_item_reg.opcode == iexu_pkg::OPC_OP;
    assign alu_b     = is_reg_op ? src_b : imm;

    iexu_alu u_alu (
        .funct3 (in_item_reg.funct3),
        .funct7 (in_item_reg.funct7),
        .is_reg (is_reg_op),
        .op_a   (src_a),
        .op_b   (alu_b),
        .result (alu_result),
        .legal  (alu_legal)
    );

    iexu_branch u_branch (
        .funct3 (in_item_reg.funct3),
        .op_a   (src_a),
        .op_b   (src_b),
        .status (br_status)
    );

    iexu_mul_div10 u_mul_div10 (
        .op_a    (src_a),
        .times10 (times10),
        .div10   (div10)
    );

    always_comb begin
        res  = '0;
        wr   = 1'b0;
        npc  = pc_plus1;
        outc = iexu_pkg::OUTCOME_DONE;
        ok   = 1'b1;
        unique case (in_item_reg.opcode)
            iexu_pkg::OPC_HALT: begin
                npc  = pc;
                outc = iexu_pkg::OUTCOME_HALT;
            end
            iexu_pkg::OPC_LOAD, iexu_pkg::OPC_LOADF, iexu_pkg::OPC_RXBU,
            iexu_pkg::OPC_TXBU, iexu_pkg::OPC_STORE, iexu_pkg::OPC_STOREF,
            iexu_pkg::OPC_OPFP: begin
                outc = iexu_pkg::OUTCOME_OTHER;
            end
            iexu_pkg::OPC_OP, iexu_pkg::OPC_OPIMM: begin
                res = alu_result;
                wr  = 1'b1;
                ok  = alu_legal;
            end
            iexu_pkg::OPC_BRANCH: begin
                ok = br_status.legal;
                if (br_status.taken) begin
                    npc = pc + imm;
                end
            end
            iexu_pkg::OPC_LUI: begin
                res = {imm[19:0], 12'h000};
                wr  = 1'b1;
            end
            iexu_pkg::OPC_AUIPC: begin
                res = pc + {imm[19:0], 12'h000};
                wr  = 1'b1;
            end
            iexu_pkg::OPC_JAL: begin
                res = pc_plus1;
                wr  = 1'b1;
                npc = pc + imm;
            end
            iexu_pkg::OPC_JALR: begin
                res = pc_plus1;
                wr  = 1'b1;
                npc = src_a + imm;
                ok  = in_item_reg.funct3 == iexu_pkg::F3_JALR;
            end
            iexu_pkg::OPC_CUSTOM: begin
                res = (in_item_reg.funct3 == iexu_pkg::F3_MUL10) ? times10 : div10;
                wr  = 1'b1;
                ok  = in_item_reg.funct7 == iexu_pkg::F7_BASE
                      && in_item_reg.rs2_field == 5'd0
                      && (in_item_reg.funct3 == iexu_pkg::F3_MUL10
                          || in_item_reg.funct3 == iexu_pkg::F3_DIV10);
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        if (!ok) begin
            res  = '0;
            wr   = 1'b0;
            npc  = pc;
            outc = iexu_pkg::OUTCOME_ILLEGAL;
        end

        out_item_next.result_value = res;
        out_item_next.write_dest   = wr;
        out_item_next.next_pc      = npc;
        out_item_next.outcome      = outc;
    end

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (stage_advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (stage_advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (stage_advance) begin
            out_item_reg <= out_item_next;
        end
    end

    `IEXU_ASSERT_SAME(a_no_accept_when_blocked, in_valid_reg && out_valid_reg && !m_ready, !s_ready)
    `IEXU_ASSERT_NEXT(a_stage_moves_to_output, stage_advance, m_valid)
    `IEXU_ASSERT_NEXT(a_output_drains, m_valid && m_ready && !in_valid_reg, !m_valid)
    `IEXU_ASSERT_SAME(a_no_write_unless_done, m_valid && m_item.outcome != iexu_pkg::OUTCOME_DONE, !m_item.write_dest)

endmodule

// ----- rtl/core/iexu_alu.sv -----
module iexu_alu (
    input  logic [2:0]  funct3,
    input  logic [6:0]  funct7,
    input  logic        is_reg,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [31:0] result,
    output logic        legal
);

    logic [4:0] shamt;

    assign shamt = op_b[4:0];

    always_comb begin
        result = '0;
        legal  = 1'b1;
        unique case (funct3)
            iexu_pkg::F3_ADD: begin
                // Only the register form decodes funct7 for add and sub.
                if (is_reg && funct7 == iexu_pkg::F7_ALT) begin
                    result = op_a - op_b;
                end else begin
                    result = op_a + op_b;
                end
                legal = !is_reg || funct7 == iexu_pkg::F7_BASE
                        || funct7 == iexu_pkg::F7_ALT;
            end
            iexu_pkg::F3_SLL:  result = op_a << shamt;
            iexu_pkg::F3_SLT:  result = {31'b0, $signed(op_a) < $signed(op_b)};
            iexu_pkg::F3_SLTU: result = {31'b0, op_a < op_b};
            iexu_pkg::F3_XOR:  result = op_a ^ op_b;
            iexu_pkg::F3_SR: begin
                if (funct7 == iexu_pkg::F7_ALT) begin
                    result = $unsigned($signed(op_a) >>> shamt);
                end else begin
                    result = op_a >> shamt;
                end
                legal = funct7 == iexu_pkg::F7_BASE || funct7 == iexu_pkg::F7_ALT;
            end
            iexu_pkg::F3_OR:   result = op_a | op_b;
            iexu_pkg::F3_AND:  result = op_a & op_b;
            default:           result = op_a & op_b;
        endcase
    end

endmodule

// ----- rtl/core/iexu_branch.sv -----
module iexu_branch (
    input  logic [2:0]               funct3,
    input  logic [31:0]              op_a,
    input  logic [31:0]              op_b,
    output iexu_pkg::branch_status_t status
);

    logic eq;
    logic lt_s;
    logic lt_u;

    assign eq   = op_a == op_b;
    assign lt_s = $signed(op_a) < $signed(op_b);
    assign lt_u = op_a < op_b;

    always_comb begin
        status.legal = 1'b1;
        status.taken = 1'b0;
        unique case (funct3)
            iexu_pkg::F3_BEQ:  status.taken = eq;
            iexu_pkg::F3_BNE:  status.taken = !eq;
            iexu_pkg::F3_BLT:  status.taken = lt_s;
            iexu_pkg::F3_BGE:  status.taken = !lt_s;
            iexu_pkg::F3_BLTU: status.taken = lt_u;
            iexu_pkg::F3_BGEU: status.taken = !lt_u;
            iexu_pkg::F3_BR2,
            iexu_pkg::F3_BR3:  status.legal = 1'b0;
            default:           status.legal = 1'b0;
        endcase
    end

endmodule

// ----- rtl/core/iexu_mul_div10.sv -----
module iexu_mul_div10 (
    input  logic [31:0] op_a,
    output logic [31:0] times10,
    output logic [31:0] div10
);

    logic [63:0] product;

    // Ten times a is 8a + 2a, kept modulo 2^32.
    assign times10 = (op_a << 3) + (op_a << 1);

    // Unsigned quotient by 10 through the scaled reciprocal.
    assign product = {32'b0, op_a} * {32'b0, iexu_pkg::RECIP10};
    assign div10   = 32'(product >> iexu_pkg::RECIP10_SHIFT);

endmodule

// ----- tb/sv/integer_execute_unit_checker.sv -----
module integer_execute_unit_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  iexu_pkg::in_item_t  s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  iexu_pkg::out_item_t m_item,
    output int                  pending_results,
    output int                  mismatch_count
);

    localparam logic [31:0] DECIMAL_BASE = 32'd10;
    localparam int          UPPER_SHIFT  = 12;

    iexu_pkg::out_item_t predicted_q[$];

    function automatic iexu_pkg::out_item_t execute_instruction(input iexu_pkg::in_item_t instr);
        iexu_pkg::out_item_t expected;
        logic [31:0] a, b, imm, pc, res, npc, operand;
        logic [1:0]  outc;
        logic        wr, legal, take;
        a     = instr.src1_value;
        b     = instr.src2_value;
        imm   = instr.immediate;
        pc    = instr.current_pc;
        res   = '0;
        npc   = pc + 32'd1;
        outc  = iexu_pkg::OUTCOME_DONE;
        wr    = 1'b0;
        legal = 1'b1;
        take  = 1'b0;
        case (instr.opcode)
            iexu_pkg::OPC_HALT: begin
                npc  = pc;
                outc = iexu_pkg::OUTCOME_HALT;
            end
            iexu_pkg::OPC_LOAD, iexu_pkg::OPC_LOADF, iexu_pkg::OPC_RXBU,
            iexu_pkg::OPC_TXBU, iexu_pkg::OPC_STORE, iexu_pkg::OPC_STOREF,
            iexu_pkg::OPC_OPFP: begin
                outc = iexu_pkg::OUTCOME_OTHER;
            end
            iexu_pkg::OPC_OP, iexu_pkg::OPC_OPIMM: begin
                operand = (instr.opcode == iexu_pkg::OPC_OP) ? b : imm;
                wr = 1'b1;
                case (instr.funct3)
                    iexu_pkg::F3_ADD: begin
                        // Immediate adds have no subtract form, so funct7 is ignored there.
                        if (instr.opcode == iexu_pkg::OPC_OPIMM ||
                            instr.funct7 == iexu_pkg::F7_BASE) begin
                            res = a + operand;
                        end else if (instr.funct7 == iexu_pkg::F7_ALT) begin
                            res = a - operand;
                        end else begin
                            legal = 1'b0;
                        end
                    end
                    iexu_pkg::F3_SLL:  res = a << operand[4:0];
                    iexu_pkg::F3_SLT:  res = {31'd0, $signed(a) < $signed(operand)};
                    iexu_pkg::F3_SLTU: res = {31'd0, a < operand};
                    iexu_pkg::F3_XOR:  res = a ^ operand;
                    iexu_pkg::F3_SR: begin
                        if (instr.funct7 == iexu_pkg::F7_BASE) begin
                            res = a >> operand[4:0];
                        end else if (instr.funct7 == iexu_pkg::F7_ALT) begin
                            res = $signed(a) >>> operand[4:0];
                        end else begin
                            legal = 1'b0;
                        end
                    end
                    iexu_pkg::F3_OR:   res = a | operand;
                    default:           res = a & operand;
                endcase
            end
            iexu_pkg::OPC_BRANCH: begin
                case (instr.funct3)
                    iexu_pkg::F3_BEQ:  take = (a == b);
                    iexu_pkg::F3_BNE:  take = (a != b);
                    iexu_pkg::F3_BLT:  take = $signed(a) < $signed(b);
                    iexu_pkg::F3_BGE:  take = $signed(a) >= $signed(b);
                    iexu_pkg::F3_BLTU: take = (a < b);
                    iexu_pkg::F3_BGEU: take = (a >= b);
                    default:           legal = 1'b0;
                endcase
                if (take) begin
                    npc = pc + imm;
                end
            end
            iexu_pkg::OPC_LUI: begin
                res = imm << UPPER_SHIFT;
                wr  = 1'b1;
            end
            iexu_pkg::OPC_AUIPC: begin
                res = pc + (imm << UPPER_SHIFT);
                wr  = 1'b1;
            end
            iexu_pkg::OPC_JAL: begin
                res = pc + 32'd1;
                wr  = 1'b1;
                npc = pc + imm;
            end
            iexu_pkg::OPC_JALR: begin
                if (instr.funct3 != iexu_pkg::F3_JALR) begin
                    legal = 1'b0;
                end else begin
                    res = pc + 32'd1;
                    wr  = 1'b1;
                    npc = a + imm;
                end
            end
            iexu_pkg::OPC_CUSTOM: begin
                if (instr.funct7 != iexu_pkg::F7_BASE || instr.rs2_field != 5'd0 ||
                    instr.funct3 > iexu_pkg::F3_DIV10) begin
                    legal = 1'b0;
                end else begin
                    res = (instr.funct3 == iexu_pkg::F3_MUL10) ? a * DECIMAL_BASE
                                                                : a / DECIMAL_BASE;
                    wr  = 1'b1;
                end
            end
            default: legal = 1'b0;
        endcase
        if (!legal) begin
            res  = '0;
            wr   = 1'b0;
            npc  = pc;
            outc = iexu_pkg::OUTCOME_ILLEGAL;
        end
        expected.result_value = res;
        expected.write_dest   = wr;
        expected.next_pc      = npc;
        expected.outcome      = outc;
        return expected;
    endfunction

    always @(posedge aclk) begin
        iexu_pkg::out_item_t want;
        if (!aresetn) begin
            predicted_q.delete();
            mismatch_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_q.push_back(execute_instruction(s_item));
            end
            if (m_valid && m_ready) begin
                if (predicted_q.size() == 0) begin
                    $error("result item arrived with no prediction waiting");
                    mismatch_count++;
                end else begin
                    want = predicted_q.pop_front();
                    if (m_item.result_value !== want.result_value) begin
                        $error("result_value: expected %h, got %h",
                               want.result_value, m_item.result_value);
                        mismatch_count++;
                    end
                    if (m_item.write_dest !== want.write_dest) begin
                        $error("write_dest: expected %b, got %b",
                               want.write_dest, m_item.write_dest);
                        mismatch_count++;
                    end
                    if (m_item.next_pc !== want.next_pc) begin
                        $error("next_pc: expected %h, got %h", want.next_pc, m_item.next_pc);
                        mismatch_count++;
                    end
                    if (m_item.outcome !== want.outcome) begin
                        $error("outcome: expected %0d, got %0d", want.outcome, m_item.outcome);
                        mismatch_count++;
                    end
                end
            end
        end
        pending_results <= predicted_q.size();
    end

endmodule

// ----- tb/sv/integer_execute_unit_tb.sv -----
module integer_execute_unit_tb;

    localparam int RESET_CYCLES    = 5;
    localparam int ITEMS_PER_PHASE = 670;
    localparam int TAIL_CYCLES     = 10;
    localparam int CYCLE_LIMIT     = 200_000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    iexu_pkg::in_item_t  s_item;
    logic                m_valid;
    logic                m_ready;
    iexu_pkg::out_item_t m_item;
    int                  pending_results;
    int                  mismatch_count;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  cycle_count;

    integer_execute_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    integer_execute_unit_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic iexu_pkg::in_item_t make_item(input logic [6:0] opc,
                                                     input logic [2:0] f3,
                                                     input logic [6:0] f7,
                                                     input logic [4:0] rs2,
                                                     input logic [31:0] imm,
                                                     input logic [31:0] a,
                                                     input logic [31:0] b,
                                                     input logic [31:0] pc);
        iexu_pkg::in_item_t instr;
        instr.opcode     = opc;
        instr.funct3     = f3;
        instr.funct7     = f7;
        instr.rs2_field  = rs2;
        instr.immediate  = imm;
        instr.src1_value = a;
        instr.src2_value = b;
        instr.current_pc = pc;
        return instr;
    endfunction

    // Operands lean toward the corners where signed and unsigned views differ.
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'($urandom_range(0, 40));
            5:       return 32'd0 - 32'($urandom_range(1, 40));
            default: return $urandom();
        endcase
    endfunction

    function automatic iexu_pkg::in_item_t random_instruction();
        iexu_pkg::in_item_t instr;
        instr = make_item(7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)),
                          7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                          rand_operand(), rand_operand(), rand_operand(), $urandom());
        if ($urandom_range(0, 99) < 12) begin
            return instr;
        end
        case ($urandom_range(0, 19))
            0, 1, 2, 3:   instr.opcode = iexu_pkg::OPC_OP;
            4, 5, 6, 7:   instr.opcode = iexu_pkg::OPC_OPIMM;
            8, 9, 10, 11: instr.opcode = iexu_pkg::OPC_BRANCH;
            12:           instr.opcode = iexu_pkg::OPC_LUI;
            13:           instr.opcode = iexu_pkg::OPC_AUIPC;
            14:           instr.opcode = iexu_pkg::OPC_JAL;
            15:           instr.opcode = iexu_pkg::OPC_JALR;
            16, 17:       instr.opcode = iexu_pkg::OPC_CUSTOM;
            18:           instr.opcode = iexu_pkg::OPC_HALT;
            default: begin
                case ($urandom_range(0, 6))
                    0:       instr.opcode = iexu_pkg::OPC_LOAD;
                    1:       instr.opcode = iexu_pkg::OPC_LOADF;
                    2:       instr.opcode = iexu_pkg::OPC_RXBU;
                    3:       instr.opcode = iexu_pkg::OPC_TXBU;
                    4:       instr.opcode = iexu_pkg::OPC_STORE;
                    5:       instr.opcode = iexu_pkg::OPC_STOREF;
                    default: instr.opcode = iexu_pkg::OPC_OPFP;
                endcase
            end
        endcase
        // Most items get legal fields; the rest keep their random ones.
        if ($urandom_range(0, 9) != 0) begin
            case (instr.opcode)
                iexu_pkg::OPC_OP, iexu_pkg::OPC_OPIMM: begin
                    if (instr.funct3 == iexu_pkg::F3_SR ||
                        (instr.funct3 == iexu_pkg::F3_ADD &&
                         instr.opcode == iexu_pkg::OPC_OP)) begin
                        instr.funct7 = $urandom_range(0, 1) ? iexu_pkg::F7_ALT
                                                            : iexu_pkg::F7_BASE;
                    end
                end
                iexu_pkg::OPC_BRANCH: begin
                    if (instr.funct3 == iexu_pkg::F3_BR2 ||
                        instr.funct3 == iexu_pkg::F3_BR3) begin
                        instr.funct3[1] = 1'b0;
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        instr.src2_value = instr.src1_value;
                    end
                    instr.immediate = 32'($signed($urandom_range(0, 200)) - 100);
                end
                iexu_pkg::OPC_JAL: instr.immediate = 32'($signed($urandom_range(0, 200)) - 100);
                iexu_pkg::OPC_JALR: instr.funct3 = iexu_pkg::F3_JALR;
                iexu_pkg::OPC_CUSTOM: begin
                    instr.funct7    = iexu_pkg::F7_BASE;
                    instr.rs2_field = 5'd0;
                    instr.funct3    = $urandom_range(0, 1) ? iexu_pkg::F3_DIV10
                                                           : iexu_pkg::F3_MUL10;
                end
                default: ;
            endcase
        end
        return instr;
    endfunction

    task automatic send_item(input iexu_pkg::in_item_t instr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= instr;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_item        = '0;
        send_idle_pct = 17;
        recv_idle_pct = 45;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every register op at the signed corners, with a PC that wraps.
        for (int f = 0; f < 8; f++) begin
            send_item(make_item(iexu_pkg::OPC_OP, 3'(f), iexu_pkg::F7_BASE, 5'd31, 32'h0,
                                32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        end
        send_item(make_item(iexu_pkg::OPC_OP, iexu_pkg::F3_ADD, iexu_pkg::F7_ALT, 5'd0,
                            32'h0, 32'h8000_0000, 32'h1, 32'h10));
        send_item(make_item(iexu_pkg::OPC_OP, iexu_pkg::F3_SR, iexu_pkg::F7_ALT, 5'd0,
                            32'h0, 32'h8000_0000, 32'd33, 32'h11));
        send_item(make_item(iexu_pkg::OPC_OP, iexu_pkg::F3_ADD, 7'h7F, 5'd0,
                            32'h0, 32'h1, 32'h1, 32'h12));
        send_item(make_item(iexu_pkg::OPC_OP, iexu_pkg::F3_XOR, 7'h7F, 5'd0,
                            32'h0, 32'hFFFF_FFFF, 32'h5, 32'h13));
        send_item(make_item(iexu_pkg::OPC_OPIMM, iexu_pkg::F3_ADD, 7'h55, 5'd7,
                            32'hFFFF_FFFF, 32'h0, 32'h0, 32'h14));
        send_item(make_item(iexu_pkg::OPC_OPIMM, iexu_pkg::F3_SR, iexu_pkg::F7_ALT, 5'd0,
                            32'h3F, 32'hFFFF_FFFE, 32'h0, 32'h15));
        // All branch encodings, including the two that have no meaning.
        for (int f = 0; f < 8; f++) begin
            send_item(make_item(iexu_pkg::OPC_BRANCH, 3'(f), iexu_pkg::F7_BASE, 5'd0,
                                32'hFFFF_FFFD, 32'hFFFF_FFFF, 32'h1, 32'h1));
        end
        send_item(make_item(iexu_pkg::OPC_LUI, 3'd0, iexu_pkg::F7_BASE, 5'd0,
                            32'h000F_FFFF, 32'h0, 32'h0, 32'h20));
        send_item(make_item(iexu_pkg::OPC_AUIPC, 3'd0, iexu_pkg::F7_BASE, 5'd0,
                            32'h1, 32'h0, 32'h0, 32'hFFFF_FFFF));
        send_item(make_item(iexu_pkg::OPC_JAL, 3'd0, iexu_pkg::F7_BASE, 5'd0,
                            32'h8000_0000, 32'h0, 32'h0, 32'h0));
        send_item(make_item(iexu_pkg::OPC_JALR, iexu_pkg::F3_JALR, iexu_pkg::F7_BASE, 5'd0,
                            32'h1, 32'h7FFF_FFFF, 32'h0, 32'h30));
        send_item(make_item(iexu_pkg::OPC_CUSTOM, iexu_pkg::F3_MUL10, iexu_pkg::F7_BASE, 5'd0,
                            32'h0, 32'h7FFF_FFFF, 32'h0, 32'h31));
        send_item(make_item(iexu_pkg::OPC_CUSTOM, iexu_pkg::F3_DIV10, iexu_pkg::F7_BASE, 5'd0,
                            32'h0, 32'hFFFF_FFFF, 32'h0, 32'h32));
        send_item(make_item(iexu_pkg::OPC_HALT, 3'd0, iexu_pkg::F7_BASE, 5'd0,
                            32'h0, 32'h0, 32'h0, 32'h40));
        send_item(make_item(iexu_pkg::OPC_LOAD, 3'd2, iexu_pkg::F7_BASE, 5'd0,
                            32'h4, 32'h0, 32'h0, 32'hFFFF_FFFF));
        send_item(make_item(7'h7F, 3'd7, 7'h7F, 5'd31, 32'h0, 32'h0, 32'h0, 32'h41));
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 45 : 0;
            recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 17 : 0;
            repeat (ITEMS_PER_PHASE) begin
                send_item(random_instruction());
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
